// File: src/bounded_deque_with_search_assert.svh
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bdq invariant violated");
`define BDQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdq implication violated");
`define BDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdq next-cycle check violated");
`else
`define BDQ_ASSERT(label, expr)
`define BDQ_ASSERT_IMPL(label, ante, cons)
`define BDQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int ACTION_W      = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_MEMBER     = 3'd4,
        ACT_CLEAR      = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

endpackage

// File: src/bdq_store.sv
// Element store: single write port, single registered read port.
module bdq_store #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic signed [bdq_pkg::DATA_W-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic signed [bdq_pkg::DATA_W-1:0] rd_data
);

    logic signed [bdq_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [bdq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit words with a membership search.
// Input channel: in_valid/in_stall carry action and value; one word per item.
// Output channel: out_valid/out_stall carry count, found and rejected; exactly
// one result word per input word, in order.
// Pushes, pops, clear and unused action codes finish in the accept cycle: the
// result is loaded into the output register on acceptance, and a new item
// can be taken every cycle while the output side keeps up.
// A member query walks the stored entries from front to back through the
// single read port of the store, one entry per cycle, and compares each word
// once the store's registered read returns it; it stops early at the first
// match and delivers from the done state. An empty deque needs no scan.
// While a query runs, in_stall is high.
// A result waits in the output register while out_stall is high; the input is
// stalled until that register can be refilled.
// Reset clears the count, the front index and all handshake state; the store
// itself is not cleared, since only entries written by inserts are ever read.
// Count is reported in 7 bits; DEPTH above 127 wraps it modulo 128.
`include "bounded_deque_with_search_assert.svh"

module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bdq_pkg::ACTION_W-1:0]        action,
    input  logic signed [bdq_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdq_pkg::COUNT_W-1:0]         count,
    output logic                                found,
    output logic                                rejected
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bdq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   issued_reg, issued_next;
    logic [CW-1:0]   left_reg, left_next;
    logic            pend_reg, pend_next;
    logic            hit_reg, hit_next;
    logic            ovalid_reg, ovalid_next;
    logic signed [bdq_pkg::DATA_W-1:0] key_reg, key_next;
    logic [bdq_pkg::COUNT_W-1:0] ocount_reg, ocount_next;
    logic            ofound_reg, ofound_next;
    logic            orej_reg, orej_next;

    logic            out_free;
    logic            accept;
    logic            full;
    logic            empty;
    logic            load_out;
    logic [CW-1:0]   res_count;
    logic            res_found;
    logic            res_rej;
    logic [AW:0]     back_sum;
    logic [AW-1:0]   back_addr;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic signed [bdq_pkg::DATA_W-1:0] rd_data;

    bdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = !((state_reg == bdq_pkg::ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // slot just past the back, wrapped into the ring
    assign back_sum  = {1'b0, front_reg} + {1'b0, count_reg[AW-1:0]};
    assign back_addr = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                    : back_sum[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        issued_next = issued_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg;
        ocount_next = ocount_reg;
        ofound_next = ofound_reg;
        orej_next   = orej_reg;
        wr_en       = 1'b0;
        wr_addr     = back_addr;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        res_count   = count_reg;
        res_found   = 1'b0;
        res_rej     = 1'b0;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (bdq_pkg::action_t'(action))
                        bdq_pkg::ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_rej = 1'b1;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                               : front_reg - 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_rej = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_rej = 1'b1;
                            end
                            else
                            begin
                                front_next = (front_reg == AW'(DEPTH - 1)) ? '0
                                                                           : front_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_rej = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::ACT_MEMBER:
                        begin
                            if (!empty)
                            begin
                                load_out    = 1'b0;
                                state_next  = bdq_pkg::ST_SCAN;
                                ptr_next    = front_reg;
                                issued_next = '0;
                                left_next   = count_reg;
                                pend_next   = 1'b0;
                                key_next    = value;
                            end
                        end
                        bdq_pkg::ACT_CLEAR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    res_count = count_next;
                end
            end
            bdq_pkg::ST_SCAN:
            begin
                pend_next = 1'b0;
                if (issued_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    issued_next = issued_reg + 1'b1;
                    ptr_next    = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                end
                // compare the word read last cycle
                if (pend_reg)
                begin
                    left_next = left_reg - 1'b1;
                    if (rd_data == key_reg)
                    begin
                        hit_next   = 1'b1;
                        state_next = bdq_pkg::ST_DONE;
                    end
                    else if (left_reg == CW'(1))
                    begin
                        hit_next   = 1'b0;
                        state_next = bdq_pkg::ST_DONE;
                    end
                end
            end
            bdq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    res_found  = hit_reg;
                    state_next = bdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            ovalid_next = 1'b1;
            ocount_next = bdq_pkg::COUNT_W'(res_count);
            ofound_next = res_found;
            orej_next   = res_rej;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bdq_pkg::ST_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            issued_reg <= '0;
            left_reg   <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        key_reg    <= key_next;
        ocount_reg <= ocount_next;
        ofound_reg <= ofound_next;
        orej_reg   <= orej_next;
    end

    assign out_valid = ovalid_reg;
    assign count     = ocount_reg;
    assign found     = ofound_reg;
    assign rejected  = orej_reg;

    `BDQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH))
    `BDQ_ASSERT_IMPL(a_store_quiet_in_scan, state_reg != bdq_pkg::ST_IDLE, !wr_en)
    `BDQ_ASSERT_IMPL(a_scan_within_seq, state_reg == bdq_pkg::ST_SCAN,
                     (issued_reg <= count_reg) && (left_reg <= count_reg) && (left_reg != '0))
    `BDQ_ASSERT_NEXT(a_simple_op_result,
                     accept && (action != bdq_pkg::ACT_MEMBER), ovalid_reg)
    `BDQ_ASSERT_NEXT(a_scan_holds_count, state_reg == bdq_pkg::ST_SCAN,
                     $stable(count_reg) && $stable(front_reg))

endmodule

// File: tb/bounded_deque_with_search_checker.sv
// Checker for the bounded deque: tracks accepted words, predicts each result and compares it.
module bounded_deque_with_search_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [COUNT_W-1:0]        count,
    input  logic                      found,
    input  logic                      rejected,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        logic               rejected;
    } deque_result_t;

    logic [DATA_W-1:0] slots [DEPTH];
    int                head_idx;
    int                fill;
    int                fail_count = 0;
    deque_result_t     awaited_results [$];

    function automatic deque_result_t apply_word(logic [ACTION_W-1:0] act,
                                                 logic [DATA_W-1:0] val);
        deque_result_t r;
        int i;
        r = '0;
        case (act)
            ACT_PUSH_FRONT:
                if (fill >= DEPTH)
                    r.rejected = 1'b1;
                else
                begin
                    head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                    slots[head_idx] = val;
                    fill++;
                end
            ACT_PUSH_BACK:
                if (fill >= DEPTH)
                    r.rejected = 1'b1;
                else
                begin
                    slots[(head_idx + fill) % DEPTH] = val;
                    fill++;
                end
            ACT_POP_FRONT:
                if (fill == 0)
                    r.rejected = 1'b1;
                else
                begin
                    head_idx = (head_idx + 1) % DEPTH;
                    fill--;
                end
            ACT_POP_BACK:
                if (fill == 0)
                    r.rejected = 1'b1;
                else
                    fill--;
            ACT_MEMBER:
                for (i = 0; i < fill; i++)
                    if (slots[(head_idx + i) % DEPTH] == val)
                        r.found = 1'b1;
            ACT_CLEAR:
            begin
                head_idx = 0;
                fill     = 0;
            end
            default:
                ;
        endcase
        r.count = COUNT_W'(fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            head_idx = 0;
            fill     = 0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: count %0d found %0b rejected %0b",
                             $time, count, found, rejected);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (count !== want.count)
                    begin
                        $display("%0t: count mismatch: expected %0d actual %0d",
                                 $time, want.count, count);
                        fail_count++;
                    end
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, found);
                        fail_count++;
                    end
                    if (rejected !== want.rejected)
                    begin
                        $display("%0t: rejected mismatch: expected %0b actual %0b",
                                 $time, want.rejected, rejected);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_word(action, value));
            outstanding <= awaited_results.size();
        end
        mismatches <= fail_count;
    end

endmodule

// File: tb/bounded_deque_with_search_test.sv
// Top of the deque testbench: clock, reset, stimulus, output stalls and the verdict.
module bounded_deque_with_search_test;
    import bdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int MODE_FILL   = 0;
    localparam int MODE_DRAIN  = 1;
    localparam int MODE_MIX    = 2;
    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 400000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [ACTION_W-1:0]       action;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_stall;
    logic [COUNT_W-1:0]        count;
    logic                      found;
    logic                      rejected;
    int                        mismatches;
    int                        outstanding;
    int                        cycles = 0;
    int                        hold_left = 0;
    int                        calm_left = 0;
    logic                      stall_next;
    bit                        quiet = 0;

    bounded_deque_with_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .found     (found),
        .rejected  (rejected)
    );

    bounded_deque_with_search_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .count       (count),
        .found       (found),
        .rejected    (rejected),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure: short random stalls, a few long ones, and calm stretches
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = out_stall;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            stall_next = 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                calm_left  = $urandom_range(20, 200);
                stall_next = 1'b0;
            end
            else if (r < 60)
            begin
                hold_left  = $urandom_range(0, 3);
                stall_next = 1'b0;
            end
            else if (r < 95)
            begin
                hold_left  = $urandom_range(0, 3);
                stall_next = 1'b1;
            end
            else
            begin
                hold_left  = $urandom_range(10, 40);
                stall_next = 1'b1;
            end
        end
        out_stall <= stall_next;
    end

    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // small values repeat often so member queries hit
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        else if (r < 60)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        else
            return $urandom;
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(int mode);
        int r;
        int push_end;
        int member_end;
        int pop_end;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                push_end = 80; member_end = 92; pop_end = 98;
            end
            MODE_DRAIN:
            begin
                push_end = 15; member_end = 30; pop_end = 98;
            end
            default:
            begin
                push_end = 35; member_end = 65; pop_end = 96;
            end
        endcase
        if (r < push_end)
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else if (r < member_end)
            return ACT_MEMBER;
        else if (r < pop_end)
            return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        else if (mode == MODE_FILL || r == 98)
            return $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        else
            return ACT_CLEAR;
    endfunction

    // holds the word until the block takes it
    task automatic send_word(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial
    begin
        int sent;
        int seg_len;
        int mode;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_PUSH_FRONT;
        value     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, spare codes, extremes, search hits and misses, stale entries after clear
        send_word(ACT_MEMBER, 32'h0);
        send_word(ACT_POP_FRONT, $urandom);
        send_word(ACT_POP_BACK, $urandom);
        send_word(ACT_SPARE_6, $urandom);
        send_word(ACT_SPARE_7, $urandom);
        send_word(ACT_PUSH_BACK, 32'h7fff_ffff);
        send_word(ACT_PUSH_FRONT, 32'h8000_0000);
        send_word(ACT_PUSH_BACK, 32'h0);
        send_word(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_word(ACT_MEMBER, 32'h8000_0000);
        send_word(ACT_MEMBER, 32'h7fff_ffff);
        send_word(ACT_MEMBER, 32'h0000_3039);
        send_word(ACT_POP_BACK, $urandom);
        send_word(ACT_MEMBER, 32'h0);
        send_word(ACT_POP_FRONT, $urandom);
        send_word(ACT_MEMBER, 32'hffff_ffff);
        send_word(ACT_SPARE_6, $urandom);
        send_word(ACT_CLEAR, $urandom);
        send_word(ACT_MEMBER, 32'h8000_0000);
        send_word(ACT_POP_FRONT, $urandom);
        send_word(ACT_PUSH_FRONT, 32'h5);
        send_word(ACT_POP_BACK, $urandom);
        send_word(ACT_POP_BACK, $urandom);

        // segments biased toward filling, draining or mixing; the first, 110 words long, is biased toward filling
        sent = 0;
        mode = MODE_FILL;
        while (sent < RANDOM_WORDS)
        begin
            seg_len = (sent == 0) ? 110 : $urandom_range(40, 120);
            if (seg_len > RANDOM_WORDS - sent)
                seg_len = RANDOM_WORDS - sent;
            quiet   = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                send_word(pick_action(mode), pick_value());
                sent++;
            end
            mode = $urandom_range(MODE_FILL, MODE_MIX);
        end
        quiet = 0;
        in_valid <= 1'b0;

        // let the checker count the last accepted word before waiting on it
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
